// ===== design/pes_pkg.sv =====
package pes_pkg;

    localparam int CFG_W       = 13;
    localparam int COORD_W     = 12;
    localparam int VALUE_W     = 10;
    localparam int COLOR_W     = 8;
    localparam int NUM_KINDS   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd640;

    typedef enum logic [2:0] {
        KIND_MAX_SUM = 3'd0,
        KIND_MIN_SUM = 3'd1,
        KIND_MAX_R   = 3'd2,
        KIND_MIN_R   = 3'd3,
        KIND_MAX_G   = 3'd4,
        KIND_MIN_G   = 3'd5,
        KIND_MAX_B   = 3'd6,
        KIND_MIN_B   = 3'd7
    } t_kind;

    // pixel word tagged with its raster position
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic               last;
    } t_pix;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [VALUE_W-1:0] value;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rec;

    function automatic logic [VALUE_W-1:0] kind_value(t_pix p, t_kind k);
        logic [VALUE_W-1:0] v;
        case (k)
            KIND_MAX_SUM, KIND_MIN_SUM:
                v = VALUE_W'(p.red) + VALUE_W'(p.green) + VALUE_W'(p.blue);
            KIND_MAX_R, KIND_MIN_R: v = VALUE_W'(p.red);
            KIND_MAX_G, KIND_MIN_G: v = VALUE_W'(p.green);
            KIND_MAX_B, KIND_MIN_B: v = VALUE_W'(p.blue);
            default:                v = '0;
        endcase
        return v;
    endfunction

    function automatic logic kind_is_max(t_kind k);
        logic m;
        case (k)
            KIND_MAX_SUM, KIND_MAX_R, KIND_MAX_G, KIND_MAX_B: m = 1'b1;
            default:                                          m = 1'b0;
        endcase
        return m;
    endfunction

    function automatic logic kind_has_color(t_kind k);
        logic c;
        case (k)
            KIND_MAX_SUM, KIND_MIN_SUM: c = 1'b1;
            default:                    c = 1'b0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/pes_front.sv =====
module pes_front import pes_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    input  logic             i_last_pixel,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_frame_width,
    input  logic             i_q_ready,
    output logic             o_q_valid,
    output t_pix             o_q_word
);

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W + 1;
    localparam logic [CMPW-1:0] WIDTH_LIMIT  = CMPW'(MAX_WIDTH);
    localparam logic [RW:0]     HEIGHT_LIMIT = (RW+1)'(MAX_HEIGHT);

    logic [CFG_W-1:0] r_width;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [CMPW-1:0]  eff_width;
    logic [CMPW-1:0]  col_inc;
    logic [RW:0]      row_inc;
    logic             accept;

    assign o_ready   = i_q_ready;
    assign o_q_valid = i_valid;
    assign accept    = i_valid && i_q_ready;

    assign o_q_word.red   = i_red;
    assign o_q_word.green = i_green;
    assign o_q_word.blue  = i_blue;
    assign o_q_word.pos_x = COORD_W'(r_col);
    assign o_q_word.pos_y = COORD_W'(r_row);
    assign o_q_word.last  = i_last_pixel;

    // zero width acts as one, oversize clamps to the maximum
    always_comb begin
        eff_width = CMPW'(r_width);
        if (r_width == '0) begin
            eff_width = CMPW'(1);
        end else if (CMPW'(r_width) > WIDTH_LIMIT) begin
            eff_width = WIDTH_LIMIT;
        end
    end

    assign col_inc = CMPW'(r_col) + CMPW'(1);
    assign row_inc = (RW+1)'(r_row) + (RW+1)'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (i_last_pixel) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= eff_width) begin
                n_col = '0;
                n_row = (row_inc >= HEIGHT_LIMIT) ? '0 : row_inc[RW-1:0];
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_width <= i_cfg_frame_width;
            end
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== design/pes_queue.sv =====
module pes_queue import pes_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_pix i_word,
    output logic o_valid,
    input  logic i_ready,
    output t_pix o_word
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_pix          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          push;
    logic          pop;

    assign o_ready = (r_count != (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/pes_back.sv =====
module pes_back import pes_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  t_pix               i_q_word,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_record_kind,
    output logic [COORD_W-1:0] o_pos_x,
    output logic [COORD_W-1:0] o_pos_y,
    output logic [VALUE_W-1:0] o_extreme_value,
    output logic [COLOR_W-1:0] o_pixel_red,
    output logic [COLOR_W-1:0] o_pixel_green,
    output logic [COLOR_W-1:0] o_pixel_blue,
    output logic               o_last_record
);

    t_rec  r_ext [NUM_KINDS];
    t_rec  n_ext [NUM_KINDS];
    t_rec  r_rpt [NUM_KINDS];
    t_rec  cur;
    logic  r_armed;
    logic  r_busy;
    t_kind r_idx;
    logic  out_fire;
    logic  rpt_done;
    logic  pop;

    assign out_fire = r_busy && i_ready;
    assign rpt_done = out_fire && (r_idx == KIND_MIN_B);
    // a frame end waits until the previous report has drained
    assign o_q_ready = !i_q_word.last || !r_busy || rpt_done;
    assign pop       = i_q_valid && o_q_ready;

    always_comb begin
        t_kind              kk;
        logic [VALUE_W-1:0] v;
        logic               take;
        kk   = KIND_MAX_SUM;
        v    = '0;
        take = 1'b0;
        for (int k = 0; k < NUM_KINDS; k++) begin
            kk   = t_kind'(3'(k));
            v    = kind_value(i_q_word, kk);
            take = !r_armed ||
                   (kind_is_max(kk) ? (v > r_ext[k].value) : (v < r_ext[k].value));
            n_ext[k] = r_ext[k];
            if (take) begin
                n_ext[k].pos_x = i_q_word.pos_x;
                n_ext[k].pos_y = i_q_word.pos_y;
                n_ext[k].value = v;
                n_ext[k].red   = kind_has_color(kk) ? i_q_word.red   : '0;
                n_ext[k].green = kind_has_color(kk) ? i_q_word.green : '0;
                n_ext[k].blue  = kind_has_color(kk) ? i_q_word.blue  : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_ext[k] <= n_ext[k];
            end
            if (i_q_word.last) begin
                for (int k = 0; k < NUM_KINDS; k++) begin
                    r_rpt[k] <= n_ext[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_busy  <= 1'b0;
            r_idx   <= KIND_MAX_SUM;
        end else begin
            // a new frame end is taken while no report runs, or as the old report finishes
            if (pop && i_q_word.last) begin
                r_busy <= 1'b1;
                r_idx  <= KIND_MAX_SUM;
            end else if (out_fire) begin
                r_idx <= t_kind'(r_idx + 3'd1);
                if (rpt_done) begin
                    r_busy <= 1'b0;
                end
            end
            if (pop) begin
                r_armed <= !i_q_word.last;
            end
        end
    end

    assign cur             = r_rpt[r_idx];
    assign o_valid         = r_busy;
    assign o_record_kind   = r_idx;
    assign o_pos_x         = cur.pos_x;
    assign o_pos_y         = cur.pos_y;
    assign o_extreme_value = cur.value;
    assign o_pixel_red     = cur.red;
    assign o_pixel_green   = cur.green;
    assign o_pixel_blue    = cur.blue;
    assign o_last_record   = (r_idx == KIND_MIN_B);

endmodule

// ===== design/pixel_extremum_statistics.sv =====
// Min/max statistics over an RGB raster stream. Pixels are taken one per clock
// while the input queue has room; column and row come from the frame_width
// register (0 acts as 1, values above MAX_WIDTH clamp). For each frame the block
// tracks the max and min R+G+B sum (with the pixel's color) and the max and min
// of R, G and B, first occurrence winning. The word marked last_pixel closes the
// frame: eight records follow on the output, kinds 0..7 in order, one per clock
// while the sink is ready, with last_record on the eighth. Records leave from a
// report bank, so pixels of the next frame keep flowing at one per clock during
// the report; a frame end reaching the back end while the previous report is
// still draining waits there (and the 4-word queue behind it then fills).
// Write frame_width only while idle.
module pixel_extremum_statistics import pes_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COLOR_W-1:0] i_red,
    input  logic [COLOR_W-1:0] i_green,
    input  logic [COLOR_W-1:0] i_blue,
    input  logic               i_last_pixel,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_frame_width,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_record_kind,
    output logic [COORD_W-1:0] o_pos_x,
    output logic [COORD_W-1:0] o_pos_y,
    output logic [VALUE_W-1:0] o_extreme_value,
    output logic [COLOR_W-1:0] o_pixel_red,
    output logic [COLOR_W-1:0] o_pixel_green,
    output logic [COLOR_W-1:0] o_pixel_blue,
    output logic               o_last_record
);

    logic q_in_valid;
    logic q_in_ready;
    t_pix q_in_word;
    logic q_out_valid;
    logic q_out_ready;
    t_pix q_out_word;

    assign o_cfg_ready = 1'b1;

    pes_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_red             (i_red),
        .i_green           (i_green),
        .i_blue            (i_blue),
        .i_last_pixel      (i_last_pixel),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_frame_width (i_cfg_frame_width),
        .i_q_ready         (q_in_ready),
        .o_q_valid         (q_in_valid),
        .o_q_word          (q_in_word)
    );

    pes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_in_valid),
        .o_ready (q_in_ready),
        .i_word  (q_in_word),
        .o_valid (q_out_valid),
        .i_ready (q_out_ready),
        .o_word  (q_out_word)
    );

    pes_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_out_valid),
        .o_q_ready       (q_out_ready),
        .i_q_word        (q_out_word),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_record_kind   (o_record_kind),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_extreme_value (o_extreme_value),
        .o_pixel_red     (o_pixel_red),
        .o_pixel_green   (o_pixel_green),
        .o_pixel_blue    (o_pixel_blue),
        .o_last_record   (o_last_record)
    );

endmodule
